// File: src/rlpm_pkg.sv
`default_nettype none
package rlpm_pkg;

	// Default table depth
	localparam int RouteEntriesDef = 32;

	// Field widths fixed by the request format
	localparam int AddrW  = 32;
	localparam int IfaceW = 4;
	localparam int SlotW  = 5;
	localparam int TtlW   = 8;
	localparam int VerdW  = 2;

	// Slots that the index field can reach
	localparam int SlotReach = 1 << SlotW;

	// Action codes
	localparam logic ActWrite   = 1'b0;
	localparam logic ActForward = 1'b1;

	// Verdict codes
	localparam logic [VerdW-1:0] VerdForward  = 2'd0;
	localparam logic [VerdW-1:0] VerdTtlExc   = 2'd1;
	localparam logic [VerdW-1:0] VerdUnreach  = 2'd2;
	localparam logic [VerdW-1:0] VerdWritten  = 2'd3;

	// Request as it travels down the cell row, with the best match so far
	typedef struct packed {
		logic              action;
		logic [SlotW-1:0]  entry_index;
		logic [AddrW-1:0]  entry_dest;
		logic [AddrW-1:0]  entry_mask;
		logic [AddrW-1:0]  entry_gateway;
		logic [IfaceW-1:0] entry_iface;
		logic              entry_valid;
		logic [AddrW-1:0]  dst_addr;
		logic [TtlW-1:0]   ttl_in;
		logic              found;
		logic [AddrW-1:0]  best_mask;
		logic [AddrW-1:0]  best_gateway;
		logic [IfaceW-1:0] best_iface;
		logic [SlotW-1:0]  best_index;
	} rlpm_req_t;

endpackage
`default_nettype wire

// File: src/rlpm_cell.sv
`default_nettype none
module rlpm_cell #(
	parameter int INDEX = 0
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      adv,
	input  wire                      d_vld,
	input  wire rlpm_pkg::rlpm_req_t d,
	output logic                     q_vld,
	output rlpm_pkg::rlpm_req_t      q
);
	import rlpm_pkg::*;

	// A slot beyond the index field's reach is never written
	localparam logic             Reachable = (INDEX < SlotReach);
	localparam logic [SlotW-1:0] SlotId    = SlotW'(INDEX % SlotReach);

	logic [AddrW-1:0]  dest_q;
	logic [AddrW-1:0]  mask_q;
	logic [AddrW-1:0]  gw_q;
	logic [IfaceW-1:0] iface_q;
	logic              used_q;

	logic      wr_hit;
	logic      take;
	rlpm_req_t nxt;

	assign wr_hit = d_vld && (d.action == ActWrite) && Reachable && (d.entry_index == SlotId);

	// Replace the running best on a matching mask of strictly greater value
	assign take = d_vld && (d.action == ActForward) && used_q
		&& ((d.dst_addr & mask_q) == (dest_q & mask_q))
		&& (!d.found || (d.best_mask < mask_q));

	always_comb begin
		nxt = d;
		if (take) begin
			nxt.found        = 1'b1;
			nxt.best_mask    = mask_q;
			nxt.best_gateway = gw_q;
			nxt.best_iface   = iface_q;
			nxt.best_index   = SlotId;
		end
	end

	// Hold this cell's route; load it when a write request passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (adv && wr_hit) begin
			used_q <= d.entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr_hit) begin
			dest_q  <= d.entry_dest;
			mask_q  <= d.entry_mask;
			gw_q    <= d.entry_gateway;
			iface_q <= d.entry_iface;
		end
	end

	// Advance the request to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_vld <= 1'b0;
		end else if (adv) begin
			q_vld <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: src/rlpm_finish.sv
`default_nettype none
module rlpm_finish (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               adv,
	input  wire                               d_vld,
	input  wire rlpm_pkg::rlpm_req_t          d,
	output logic                              out_valid,
	output logic [rlpm_pkg::VerdW-1:0]        verdict,
	output logic [rlpm_pkg::TtlW-1:0]         ttl_out,
	output logic [rlpm_pkg::IfaceW-1:0]       out_iface,
	output logic [rlpm_pkg::AddrW-1:0]        hop_addr,
	output logic [rlpm_pkg::SlotW-1:0]        matched_index
);
	import rlpm_pkg::*;

	logic [VerdW-1:0]  verd_c;
	logic [TtlW-1:0]   ttl_c;
	logic [IfaceW-1:0] iface_c;
	logic [AddrW-1:0]  hop_c;
	logic [SlotW-1:0]  idx_c;

	// Form the verdict from the action, the TTL and the best match
	always_comb begin
		verd_c  = VerdWritten;
		ttl_c   = d.ttl_in;
		iface_c = '0;
		hop_c   = '0;
		idx_c   = '0;
		if (d.action == ActForward) begin
			if (d.ttl_in <= TtlW'(1)) begin
				verd_c = VerdTtlExc;
			end else if (!d.found) begin
				verd_c = VerdUnreach;
			end else begin
				verd_c  = VerdForward;
				ttl_c   = d.ttl_in - TtlW'(1);
				iface_c = d.best_iface;
				hop_c   = (d.best_gateway != '0) ? d.best_gateway : d.dst_addr;
				idx_c   = d.best_index;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			verdict       <= verd_c;
			ttl_out       <= ttl_c;
			out_iface     <= iface_c;
			hop_addr      <= hop_c;
			matched_index <= idx_c;
		end
	end

endmodule
`default_nettype wire

// File: src/route_lpm_forward_decision.sv
`default_nettype none
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | action, entry_*, dst_addr, ttl_in
// out     | output    | out_valid / out_stall | verdict, ttl_out, out_iface, hop_addr,
//         |           |                       | matched_index
//
// A request walks a row of ROUTE_ENTRIES cells, one cell per cycle while the row
// is not stalled, then a result register; one request per cycle unless stalled.
// Each cell holds one route; writes and lookups pass in order, so a lookup
// sees every earlier write. Reset empties the table at once.
// A stalled result freezes the whole row, and in_stall follows.
module route_lpm_forward_decision #(
	parameter int ROUTE_ENTRIES = rlpm_pkg::RouteEntriesDef
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               action,
	input  wire  [rlpm_pkg::SlotW-1:0]        entry_index,
	input  wire  [rlpm_pkg::AddrW-1:0]        entry_dest,
	input  wire  [rlpm_pkg::AddrW-1:0]        entry_mask,
	input  wire  [rlpm_pkg::AddrW-1:0]        entry_gateway,
	input  wire  [rlpm_pkg::IfaceW-1:0]       entry_iface,
	input  wire                               entry_valid,
	input  wire  [rlpm_pkg::AddrW-1:0]        dst_addr,
	input  wire  [rlpm_pkg::TtlW-1:0]         ttl_in,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [rlpm_pkg::VerdW-1:0]        verdict,
	output logic [rlpm_pkg::TtlW-1:0]         ttl_out,
	output logic [rlpm_pkg::IfaceW-1:0]       out_iface,
	output logic [rlpm_pkg::AddrW-1:0]        hop_addr,
	output logic [rlpm_pkg::SlotW-1:0]        matched_index
);
	import rlpm_pkg::*;

	logic      adv;
	logic      link_vld [ROUTE_ENTRIES+1];
	rlpm_req_t link     [ROUTE_ENTRIES+1];

	// Advance the row unless a finished result is held
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Pack the incoming request with an empty best match
	assign link_vld[0] = in_valid;
	always_comb begin
		link[0].action        = action;
		link[0].entry_index   = entry_index;
		link[0].entry_dest    = entry_dest;
		link[0].entry_mask    = entry_mask;
		link[0].entry_gateway = entry_gateway;
		link[0].entry_iface   = entry_iface;
		link[0].entry_valid   = entry_valid;
		link[0].dst_addr      = dst_addr;
		link[0].ttl_in        = ttl_in;
		link[0].found         = 1'b0;
		link[0].best_mask     = '0;
		link[0].best_gateway  = '0;
		link[0].best_iface    = '0;
		link[0].best_index    = '0;
	end

	// Row of route cells
	for (genvar k = 0; k < ROUTE_ENTRIES; k++) begin : g_cell
		rlpm_cell #(
			.INDEX(k)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.d_vld (link_vld[k]),
			.d     (link[k]),
			.q_vld (link_vld[k+1]),
			.q     (link[k+1])
		);
	end

	// Result register
	rlpm_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.d_vld        (link_vld[ROUTE_ENTRIES]),
		.d            (link[ROUTE_ENTRIES]),
		.out_valid    (out_valid),
		.verdict      (verdict),
		.ttl_out      (ttl_out),
		.out_iface    (out_iface),
		.hop_addr     (hop_addr),
		.matched_index(matched_index)
	);

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rlpm_pkg::*;

	localparam int RouteSlots  = RouteEntriesDef;
	localparam int Phase1End   = 450;
	localparam int Phase2End   = 900;
	localparam int PressureAt  = 950;
	localparam int HoldCycles  = 200;
	localparam int DrainCycles = RouteSlots + 8;
	localparam int CycleLimit  = 200000;

	typedef struct {
		logic              action;
		logic [SlotW-1:0]  slot;
		logic [AddrW-1:0]  dest;
		logic [AddrW-1:0]  mask;
		logic [AddrW-1:0]  gateway;
		logic [IfaceW-1:0] iface;
		logic              valid;
		logic [AddrW-1:0]  dst;
		logic [TtlW-1:0]   ttl;
	} route_req_t;

	typedef struct {
		logic [VerdW-1:0]  verdict;
		logic [TtlW-1:0]   ttl;
		logic [IfaceW-1:0] iface;
		logic [AddrW-1:0]  hop;
		logic [SlotW-1:0]  slot;
	} route_res_t;

	logic clk;
	logic arst_n;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = ActWrite;
	logic [SlotW-1:0]  entry_index = '0;
	logic [AddrW-1:0]  entry_dest = '0;
	logic [AddrW-1:0]  entry_mask = '0;
	logic [AddrW-1:0]  entry_gateway = '0;
	logic [IfaceW-1:0] entry_iface = '0;
	logic              entry_valid = 1'b0;
	logic [AddrW-1:0]  dst_addr = '0;
	logic [TtlW-1:0]   ttl_in = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [VerdW-1:0]  verdict;
	logic [TtlW-1:0]   ttl_out;
	logic [IfaceW-1:0] out_iface;
	logic [AddrW-1:0]  hop_addr;
	logic [SlotW-1:0]  matched_index;

	route_lpm_forward_decision dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.entry_index   (entry_index),
		.entry_dest    (entry_dest),
		.entry_mask    (entry_mask),
		.entry_gateway (entry_gateway),
		.entry_iface   (entry_iface),
		.entry_valid   (entry_valid),
		.dst_addr      (dst_addr),
		.ttl_in        (ttl_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.ttl_out       (ttl_out),
		.out_iface     (out_iface),
		.hop_addr      (hop_addr),
		.matched_index (matched_index)
	);

	// Route table mirror used to predict decisions
	logic [AddrW-1:0]  tbl_dest    [RouteSlots];
	logic [AddrW-1:0]  tbl_mask    [RouteSlots];
	logic [AddrW-1:0]  tbl_gateway [RouteSlots];
	logic [IfaceW-1:0] tbl_iface   [RouteSlots];
	logic              tbl_valid   [RouteSlots];

	// Routes as written by the stimulus, used to aim lookups at them
	logic [AddrW-1:0] gen_dest [RouteSlots];
	logic [AddrW-1:0] gen_mask [RouteSlots];

	route_req_t pending[$];
	route_res_t expected[$];
	route_req_t cur;

	int taken = 0;
	int errors = 0;
	int cycle_count = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	int tx_idle_pct [3] = '{17, 72, 0};
	int rx_idle_pct [3] = '{72, 17, 0};
	int phase;

	assign phase = (taken < Phase1End) ? 0 : (taken < Phase2End) ? 1 : 2;

	// Apply one request to the table mirror and return its decision
	function automatic route_res_t route_decide(route_req_t r);
		route_res_t res;
		logic found;
		int best;
		res = '{verdict: VerdWritten, ttl: r.ttl, iface: '0, hop: '0, slot: '0};
		found = 1'b0;
		best = 0;
		if (r.action == ActWrite) begin
			if (int'(r.slot) < RouteSlots) begin
				tbl_dest[r.slot]    = r.dest;
				tbl_mask[r.slot]    = r.mask;
				tbl_gateway[r.slot] = r.gateway;
				tbl_iface[r.slot]   = r.iface;
				tbl_valid[r.slot]   = r.valid;
			end
			return res;
		end
		if (r.ttl <= 8'd1) begin
			res.verdict = VerdTtlExc;
			return res;
		end
		for (int i = 0; i < RouteSlots; i++) begin
			if (tbl_valid[i] && ((r.dst & tbl_mask[i]) == (tbl_dest[i] & tbl_mask[i]))) begin
				if (!found || tbl_mask[i] > tbl_mask[best]) begin
					best = i;
					found = 1'b1;
				end
			end
		end
		if (!found) begin
			res.verdict = VerdUnreach;
			return res;
		end
		res.verdict = VerdForward;
		res.ttl     = r.ttl - 8'd1;
		res.iface   = tbl_iface[best];
		res.hop     = (tbl_gateway[best] != '0) ? tbl_gateway[best] : r.dst;
		res.slot    = SlotW'(best);
		return res;
	endfunction

	function automatic logic [AddrW-1:0] prefix_mask(int plen);
		return (plen == 0) ? '0 : ~((32'h1 << (32 - plen)) - 32'h1);
	endfunction

	// Build a route write; unused lookup fields carry random filler
	function automatic route_req_t wr_req(logic [SlotW-1:0] slot, logic [AddrW-1:0] dest,
			logic [AddrW-1:0] mask, logic [AddrW-1:0] gw, logic [IfaceW-1:0] iface,
			logic valid);
		route_req_t r;
		r = '{action: ActWrite, slot: slot, dest: dest, mask: mask, gateway: gw,
			iface: iface, valid: valid, dst: $urandom, ttl: TtlW'($urandom)};
		gen_dest[slot] = dest;
		gen_mask[slot] = mask;
		return r;
	endfunction

	// Build a lookup; unused write fields carry random filler
	function automatic route_req_t fwd_req(logic [AddrW-1:0] dst, logic [TtlW-1:0] ttl);
		route_req_t r;
		r = '{action: ActForward, slot: SlotW'($urandom), dest: $urandom, mask: $urandom,
			gateway: $urandom, iface: IfaceW'($urandom), valid: 1'($urandom),
			dst: dst, ttl: ttl};
		return r;
	endfunction

	task automatic report(string field, logic [AddrW-1:0] got, logic [AddrW-1:0] want);
		$display("mismatch %s: got %h want %h", field, got, want);
		errors++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stimulus, reset and end of run
	initial begin
		int s;
		int plen;
		int sel;
		logic [AddrW-1:0] m;
		logic [AddrW-1:0] d;
		logic [TtlW-1:0] t;
		for (int i = 0; i < RouteSlots; i++) begin
			tbl_dest[i] = '0;
			tbl_mask[i] = '0;
			tbl_gateway[i] = '0;
			tbl_iface[i] = '0;
			tbl_valid[i] = 1'b0;
			gen_dest[i] = '0;
			gen_mask[i] = '0;
		end
		arst_n = 1'b0;

		// Empty table, TTL limits, default route, equal-mask tie, host route,
		// disabled entry, non-contiguous mask, all-ones entry
		pending.push_back(fwd_req(32'hC0A8_0001, 8'd64));
		pending.push_back(fwd_req(32'h0A00_0001, 8'd0));
		pending.push_back(fwd_req(32'h0A00_0001, 8'd1));
		pending.push_back(wr_req(5'd31, 32'h0, 32'h0, 32'h0A00_0001, 4'd15, 1'b1));
		pending.push_back(fwd_req(32'hFFFF_FFFF, 8'd2));
		pending.push_back(wr_req(5'd0, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 4'd1, 1'b1));
		pending.push_back(wr_req(5'd1, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0101, 4'd2, 1'b1));
		pending.push_back(fwd_req(32'h0A01_0203, 8'd255));
		pending.push_back(wr_req(5'd2, 32'h0A01_0200, 32'hFFFF_FF00, 32'hFFFF_FFFF, 4'd3, 1'b1));
		pending.push_back(fwd_req(32'h0A01_0203, 8'd64));
		pending.push_back(wr_req(5'd3, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0, 4'd0, 1'b0));
		pending.push_back(fwd_req(32'h0A01_0203, 8'd2));
		pending.push_back(wr_req(5'd3, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0, 4'd0, 1'b1));
		pending.push_back(fwd_req(32'h0A01_0203, 8'd17));
		pending.push_back(wr_req(5'd4, 32'h0B00_0C00, 32'hFF00_FF00, 32'h0, 4'd4, 1'b1));
		pending.push_back(fwd_req(32'h0B99_0C77, 8'd33));
		pending.push_back(fwd_req(32'h0000_0000, 8'd128));
		pending.push_back(wr_req(5'd31, 32'h0, 32'h0, 32'h0A00_0001, 4'd15, 1'b0));
		pending.push_back(fwd_req(32'h0C00_0000, 8'd9));
		pending.push_back(fwd_req(32'h0A01_0203, 8'd1));
		pending.push_back(wr_req(5'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1));
		pending.push_back(fwd_req(32'hFFFF_FFFF, 8'd255));
		pending.push_back(wr_req(5'd0, 32'h0, 32'h0, 32'h0, 4'd0, 1'b0));
		pending.push_back(fwd_req(32'h0A00_0001, 8'd3));

		// Random mix: mostly prefix route writes, and lookups mostly aimed at stored routes
		for (int n = 0; n < 1330; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				s = $urandom_range(0, RouteSlots - 1);
				plen = $urandom_range(0, 32);
				m = ($urandom_range(0, 9) == 0) ? $urandom : prefix_mask(plen);
				d = ($urandom_range(0, 4) == 0) ? $urandom : ($urandom & m);
				pending.push_back(wr_req(SlotW'(s), d, m,
					($urandom_range(0, 1) == 0) ? 32'h0 : $urandom,
					IfaceW'($urandom), ($urandom_range(0, 99) < 85)));
			end else begin
				s = $urandom_range(0, RouteSlots - 1);
				if ($urandom_range(0, 99) < 60)
					d = (gen_dest[s] & gen_mask[s]) | ($urandom & ~gen_mask[s]);
				else
					d = $urandom;
				sel = $urandom_range(0, 99);
				if (sel < 10)
					t = TtlW'($urandom_range(0, 1));
				else if (sel < 15)
					t = 8'd255;
				else
					t = TtlW'($urandom_range(0, 255));
				pending.push_back(fwd_req(d, t));
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every result to come out
		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (expected.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Driver: predict on acceptance, then offer the next request or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected.push_back(route_decide(cur));
				taken <= taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct[phase]) begin
					cur = pending.pop_front();
					action        <= cur.action;
					entry_index   <= cur.slot;
					entry_dest    <= cur.dest;
					entry_mask    <= cur.mask;
					entry_gateway <= cur.gateway;
					entry_iface   <= cur.iface;
					entry_valid   <= cur.valid;
					dst_addr      <= cur.dst;
					ttl_in        <= cur.ttl;
					in_valid      <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off once, to fill the pipeline and push back on input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && taken >= PressureAt) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		route_res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected.size() == 0) begin
					report("result with no request pending", 32'(verdict), '0);
				end else begin
					want = expected.pop_front();
					if (verdict !== want.verdict)
						report("verdict", 32'(verdict), 32'(want.verdict));
					if (ttl_out !== want.ttl)
						report("ttl_out", 32'(ttl_out), 32'(want.ttl));
					if (out_iface !== want.iface)
						report("out_iface", 32'(out_iface), 32'(want.iface));
					if (hop_addr !== want.hop)
						report("hop_addr", hop_addr, want.hop);
					if (matched_index !== want.slot)
						report("matched_index", 32'(matched_index), 32'(want.slot));
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct[phase]);
		end
	end

	// Guard against a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule
